>>> rtl/core/dmt_pkg.sv
package dmt_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  // opcodes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // result status codes
  localparam logic [2:0] ST_ADDED    = 3'd0;
  localparam logic [2:0] ST_MERGED   = 3'd1;
  localparam logic [2:0] ST_ZERO     = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_READ_OK  = 3'd4;
  localparam logic [2:0] ST_READ_BAD = 3'd5;
  localparam logic [2:0] ST_CLEARED  = 3'd6;

  // command broadcast to every cell while an item is in flight
  typedef struct packed {
    logic [63:0]      key;
    logic [31:0]      stamp;
    logic             mark;
    logic [IDX_W-1:0] read_idx;
    logic [CNT_W-1:0] count;
    logic             app_we;
  } cmd_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic             live;
    logic             is_read;
    logic             found;
    logic [IDX_W-1:0] pos;
    logic [63:0]      key;
    logic [31:0]      stamp;
    logic             flag;
  } tok_t;

endpackage

>>> rtl/core/dmt_cell.sv
module dmt_cell
  import dmt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] cell_idx,
  input  cmd_t             cmd,
  input  tok_t             tok_in,
  output tok_t             tok_out
);

  logic [63:0] key_r;
  logic [31:0] stamp_r;
  logic        flag_r;
  logic [63:0] key_nxt;
  logic [31:0] stamp_nxt;
  logic        flag_nxt;
  tok_t        tok_r;
  tok_t        tok_nxt;
  logic        in_use;
  logic        hit;

  // record lookup and merge for the token passing through
  always_comb begin
    in_use    = {{(CNT_W - IDX_W){1'b0}}, cell_idx} < cmd.count;
    key_nxt   = key_r;
    stamp_nxt = stamp_r;
    flag_nxt  = flag_r;
    tok_nxt   = tok_in;
    hit       = 1'b0;
    if (tok_in.live) begin
      if (tok_in.is_read) begin
        hit = (cell_idx == cmd.read_idx);
      end else begin
        hit = !tok_in.found && in_use && (key_r == cmd.key);
        if (hit) begin
          if (cmd.mark) flag_nxt = 1'b1;
          if ((cmd.stamp != 32'd0) && (stamp_r == 32'd0)) stamp_nxt = cmd.stamp;
        end
      end
    end
    if (hit) begin
      tok_nxt.found = 1'b1;
      tok_nxt.pos   = cell_idx;
      tok_nxt.key   = key_nxt;
      tok_nxt.stamp = stamp_nxt;
      tok_nxt.flag  = flag_nxt;
    end
    // append of a new record at the fill position
    if (cmd.app_we && ({{(CNT_W - IDX_W){1'b0}}, cell_idx} == cmd.count)) begin
      key_nxt   = cmd.key;
      stamp_nxt = cmd.stamp;
      flag_nxt  = cmd.mark;
    end
  end

  // record storage
  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    stamp_r <= stamp_nxt;
    flag_r  <= flag_nxt;
  end

  // token register towards the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.live <= 1'b0;
    end else begin
      tok_r.live <= tok_nxt.live;
    end
    tok_r.is_read <= tok_nxt.is_read;
    tok_r.found   <= tok_nxt.found;
    tok_r.pos     <= tok_nxt.pos;
    tok_r.key     <= tok_nxt.key;
    tok_r.stamp   <= tok_nxt.stamp;
    tok_r.flag    <= tok_nxt.flag;
  end

  assign tok_out = tok_r;

endmodule

>>> rtl/core/dedup_merge_table_core.sv
// channel   | ports                                   | transfer
// ----------+-----------------------------------------+--------------------------
// command   | start, busy, in_*                       | start high, busy low
// result    | out_valid, out_*                        | out_valid high, one cycle
//
// clear, zero-key insert, insert into a full table, an unused opcode and any read
// outside the count or limit give their result in the cycle after the transfer;
// busy stays low. an insert or an in-range read walks a token down the row of
// TABLE_DEPTH cells, one cell a cycle, and the result is registered at its end.
// synchronous active-low reset empties the table; no clearing pass is needed.
// results cannot be held off, so busy only covers the walk through the cells.
module dedup_merge_table_core
  import dmt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_opcode,
  input  logic [63:0] in_key_hash,
  input  logic [31:0] in_stamp,
  input  logic        in_unloaded_mark,
  input  logic [7:0]  in_read_index,
  input  logic [8:0]  in_read_limit,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [7:0]  out_entry_pos,
  output logic [63:0] out_key,
  output logic [31:0] out_stamp,
  output logic        out_unloaded,
  output logic [8:0]  out_entry_count
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_WALK = 1'b1;

  logic             state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             launch_r, launch_nxt;
  logic             is_read_r;
  logic [63:0]      key_r;
  logic [31:0]      stamp_r;
  logic             mark_r;
  logic [IDX_W-1:0] idx_r;

  logic             res_valid_nxt;
  logic [2:0]       res_status_nxt;
  logic [7:0]       res_pos_nxt;
  logic [63:0]      res_key_nxt;
  logic [31:0]      res_stamp_nxt;
  logic             res_flag_nxt;
  logic             app_we;

  logic             valid_r;
  logic [2:0]       status_r;
  logic [7:0]       pos_r;
  logic [63:0]      okey_r;
  logic [31:0]      ostamp_r;
  logic             oflag_r;
  logic [8:0]       ocount_r;

  logic             accept;
  logic             full;
  logic             rd_ok;
  cmd_t             cmd;
  tok_t             tok [TABLE_DEPTH+1];
  tok_t             tok_end;

  assign busy    = (state_r == S_WALK);
  assign accept  = start && !busy;
  assign full    = (count_r == CNT_W'(TABLE_DEPTH));
  assign rd_ok   = ({1'b0, in_read_index} < in_read_limit) &&
                   (16'(in_read_index) < 16'(count_r));
  assign tok_end = tok[TABLE_DEPTH];

  // command control and result selection
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    launch_nxt     = 1'b0;
    app_we         = 1'b0;
    res_valid_nxt  = 1'b0;
    res_status_nxt = ST_READ_BAD;
    res_pos_nxt    = 8'd0;
    res_key_nxt    = 64'd0;
    res_stamp_nxt  = 32'd0;
    res_flag_nxt   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_opcode)
            OP_INSERT: begin
              if (in_key_hash == 64'd0) begin
                res_valid_nxt  = 1'b1;
                res_status_nxt = ST_ZERO;
              end else if (full) begin
                res_valid_nxt  = 1'b1;
                res_status_nxt = ST_FULL;
              end else begin
                launch_nxt = 1'b1;
                state_nxt  = S_WALK;
              end
            end
            OP_READ: begin
              if (rd_ok) begin
                launch_nxt = 1'b1;
                state_nxt  = S_WALK;
              end else begin
                res_valid_nxt  = 1'b1;
                res_status_nxt = ST_READ_BAD;
              end
            end
            OP_CLEAR: begin
              count_nxt      = '0;
              res_valid_nxt  = 1'b1;
              res_status_nxt = ST_CLEARED;
            end
            default: begin
              res_valid_nxt  = 1'b1;
              res_status_nxt = ST_READ_BAD;
            end
          endcase
        end
      end
      S_WALK: begin
        if (tok_end.live) begin
          state_nxt     = S_IDLE;
          res_valid_nxt = 1'b1;
          if (tok_end.found) begin
            res_status_nxt = tok_end.is_read ? ST_READ_OK : ST_MERGED;
            res_pos_nxt    = 8'(tok_end.pos);
            res_key_nxt    = tok_end.key;
            res_stamp_nxt  = tok_end.stamp;
            res_flag_nxt   = tok_end.flag;
          end else begin
            // no key matched: append at the fill position
            app_we         = 1'b1;
            count_nxt      = count_r + CNT_W'(1);
            res_status_nxt = ST_ADDED;
            res_pos_nxt    = 8'(count_r);
            res_key_nxt    = key_r;
            res_stamp_nxt  = stamp_r;
            res_flag_nxt   = mark_r;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      launch_r <= 1'b0;
      valid_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      launch_r <= launch_nxt;
      valid_r  <= res_valid_nxt;
    end
  end

  // captured command and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      is_read_r <= (in_opcode == OP_READ);
      key_r     <= in_key_hash;
      stamp_r   <= in_stamp;
      mark_r    <= in_unloaded_mark;
      idx_r     <= IDX_W'(in_read_index);
    end
    status_r <= res_status_nxt;
    pos_r    <= res_pos_nxt;
    okey_r   <= res_key_nxt;
    ostamp_r <= res_stamp_nxt;
    oflag_r  <= res_flag_nxt;
    ocount_r <= 9'(count_nxt);
  end

  // broadcast to the cells and token entry
  always_comb begin
    cmd.key      = key_r;
    cmd.stamp    = stamp_r;
    cmd.mark     = mark_r;
    cmd.read_idx = idx_r;
    cmd.count    = count_r;
    cmd.app_we   = app_we;

    tok[0].live    = launch_r;
    tok[0].is_read = is_read_r;
    tok[0].found   = 1'b0;
    tok[0].pos     = '0;
    tok[0].key     = '0;
    tok[0].stamp   = '0;
    tok[0].flag    = 1'b0;
  end

  // row of record cells
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    dmt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(i)),
      .cmd      (cmd),
      .tok_in   (tok[i]),
      .tok_out  (tok[i+1])
    );
  end

  assign out_valid       = valid_r;
  assign out_status      = status_r;
  assign out_entry_pos   = pos_r;
  assign out_key         = okey_r;
  assign out_stamp       = ostamp_r;
  assign out_unloaded    = oflag_r;
  assign out_entry_count = ocount_r;

endmodule

>>> tb/dedup_merge_table_core_tb.sv
module dedup_merge_table_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dmt_pkg::*;

  // opcode with no function in the block
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // cycles with no transfer on either side before the run is abandoned
  localparam int STALL_LIMIT = 5000;
  localparam int TAIL_CYCLES = 300;
  localparam int MAX_REPORTS = 100;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  pos;
    logic [63:0] key;
    logic [31:0] stamp;
    logic        flag;
    logic [8:0]  count;
  } reply_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_opcode;
  logic [63:0] in_key_hash;
  logic [31:0] in_stamp;
  logic        in_unloaded_mark;
  logic [7:0]  in_read_index;
  logic [8:0]  in_read_limit;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [7:0]  out_entry_pos;
  logic [63:0] out_key;
  logic [31:0] out_stamp;
  logic        out_unloaded;
  logic [8:0]  out_entry_count;

  // shadow copy of the record table
  logic [63:0] shadow_key [TABLE_DEPTH];
  logic [31:0] shadow_stamp [TABLE_DEPTH];
  logic        shadow_flag [TABLE_DEPTH];
  int          shadow_count;

  reply_t      due_replies[$];
  int          send_idle_pct;
  int          fail_count;

  dedup_merge_table_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_opcode       (in_opcode),
    .in_key_hash     (in_key_hash),
    .in_stamp        (in_stamp),
    .in_unloaded_mark(in_unloaded_mark),
    .in_read_index   (in_read_index),
    .in_read_limit   (in_read_limit),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_entry_pos   (out_entry_pos),
    .out_key         (out_key),
    .out_stamp       (out_stamp),
    .out_unloaded    (out_unloaded),
    .out_entry_count (out_entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // apply one command to the shadow table and return the reply it gives
  function automatic reply_t table_reply(input logic [1:0] op, input logic [63:0] key,
                                         input logic [31:0] stamp, input logic mark,
                                         input logic [7:0] idx, input logic [8:0] lim);
    reply_t r;
    int     hit;
    int     i;
    r = '0;
    hit = -1;
    case (op)
      OP_INSERT: begin
        if (key == '0) begin
          r.status = ST_ZERO;
        end else if (shadow_count >= TABLE_DEPTH) begin
          // dropped even when the key is already held
          r.status = ST_FULL;
        end else begin
          for (i = 0; i < shadow_count; i++) begin
            if (hit < 0 && shadow_key[i] == key) hit = i;
          end
          if (hit >= 0) begin
            if (mark) shadow_flag[hit] = 1'b1;
            // stamp is only filled while still unknown
            if (stamp != '0 && shadow_stamp[hit] == '0) shadow_stamp[hit] = stamp;
            r.status = ST_MERGED;
          end else begin
            hit = shadow_count;
            shadow_key[hit] = key;
            shadow_stamp[hit] = stamp;
            shadow_flag[hit] = mark;
            shadow_count++;
            r.status = ST_ADDED;
          end
        end
      end
      OP_READ: begin
        if (int'(idx) < shadow_count && {1'b0, idx} < lim) begin
          hit = int'(idx);
          r.status = ST_READ_OK;
        end else begin
          r.status = ST_READ_BAD;
        end
      end
      OP_CLEAR: begin
        shadow_count = 0;
        r.status = ST_CLEARED;
      end
      default: begin
        r.status = ST_READ_BAD;
      end
    endcase
    if (hit >= 0) begin
      r.pos = hit[7:0];
      r.key = shadow_key[hit];
      r.stamp = shadow_stamp[hit];
      r.flag = shadow_flag[hit];
    end
    r.count = shadow_count[8:0];
    return r;
  endfunction

  // one command transfer, after a random idle gap
  task automatic send_cmd(input logic [1:0] op, input logic [63:0] key,
                          input logic [31:0] stamp, input logic mark,
                          input logic [7:0] idx, input logic [8:0] lim);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_opcode <= op;
    in_key_hash <= key;
    in_stamp <= stamp;
    in_unloaded_mark <= mark;
    in_read_index <= idx;
    in_read_limit <= lim;
    @(posedge clk);
    while (busy) @(posedge clk);
    due_replies.push_back(table_reply(op, key, stamp, mark, idx, lim));
  endtask

  // hold the sender off until every reply is back
  task automatic wait_for_replies();
    start <= 1'b0;
    while (due_replies.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // every result transfer against the oldest expected reply
  always @(posedge clk) begin : reply_check
    reply_t want;
    if (rst_n && out_valid) begin
      if (due_replies.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual status %0d",
                   $time, out_status);
      end else begin
        want = due_replies.pop_front();
        check_field("status", 64'(want.status), 64'(out_status));
        check_field("entry_pos", 64'(want.pos), 64'(out_entry_pos));
        check_field("key", want.key, out_key);
        check_field("stamp", 64'(want.stamp), 64'(out_stamp));
        check_field("unloaded", 64'(want.flag), 64'(out_unloaded));
        check_field("entry_count", 64'(want.count), 64'(out_entry_count));
      end
    end
  end

  // give up when neither side transfers for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_valid) quiet = 0;
      else quiet++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // merges, stamp fill, flag set, read bounds, unused opcode, clear
  task automatic test_directed_cases();
    send_idle_pct = 0;
    send_cmd(OP_READ, '0, '0, 1'b0, 8'd0, 9'd256);
    send_cmd(OP_INSERT, '0, 32'hFFFF_FFFF, 1'b1, 8'd0, 9'd0);
    send_cmd(OP_INSERT, '1, '0, 1'b0, 8'd0, 9'd0);
    send_cmd(OP_INSERT, 64'd1, 32'hFFFF_FFFF, 1'b1, 8'd0, 9'd0);
    send_cmd(OP_INSERT, '1, 32'd5, 1'b0, 8'd0, 9'd0);
    send_cmd(OP_INSERT, '1, 32'hFFFF_FFFF, 1'b1, 8'd0, 9'd0);
    send_cmd(OP_INSERT, 64'd1, '0, 1'b0, 8'd0, 9'd0);
    send_cmd(OP_INSERT, 64'h8000_0000_0000_0000, 32'hA5A5_5A5A, 1'b0, 8'd0, 9'd0);
    send_cmd(OP_READ, '0, '0, 1'b0, 8'd2, 9'd256);
    send_cmd(OP_READ, '0, '0, 1'b0, 8'd3, 9'd256);
    send_cmd(OP_READ, '0, '0, 1'b0, 8'd1, 9'd1);
    send_cmd(OP_READ, '0, '0, 1'b0, 8'd0, 9'd1);
    send_cmd(OP_READ, '0, '0, 1'b0, 8'd0, 9'd0);
    send_cmd(OP_READ, '0, '0, 1'b0, 8'd255, 9'd511);
    send_cmd(OP_READ, '0, '0, 1'b0, 8'd1, 9'd511);
    send_cmd(OP_UNUSED, '1, '1, 1'b1, 8'd1, 9'd511);
    send_cmd(OP_CLEAR, '1, '1, 1'b1, 8'd255, 9'd511);
    send_cmd(OP_READ, '0, '0, 1'b0, 8'd0, 9'd256);
    send_cmd(OP_INSERT, '1, 32'd7, 1'b0, 8'd0, 9'd0);
    send_cmd(OP_READ, '0, '0, 1'b0, 8'd0, 9'd256);
    send_cmd(OP_CLEAR, '0, '0, 1'b0, 8'd0, 9'd0);
  endtask

  // fill every slot, then probe the full table
  task automatic test_full_table();
    int          i;
    logic [63:0] key;
    logic [63:0] held_key;
    logic [31:0] stamp;
    send_idle_pct = 14;
    held_key = '0;
    for (i = 0; i < TABLE_DEPTH; i++) begin
      key = {$urandom, 23'd0, 1'b1, i[7:0]};
      if (i == 17) held_key = key;
      stamp = ($urandom_range(3) == 0) ? '0 : $urandom;
      send_cmd(OP_INSERT, key, stamp, 1'($urandom_range(1)), 8'd0, 9'd0);
    end
    wait_for_replies();
    send_cmd(OP_INSERT, held_key, 32'd9, 1'b1, 8'd0, 9'd0);
    send_cmd(OP_INSERT, {$urandom, $urandom}, 32'd9, 1'b1, 8'd0, 9'd0);
    send_cmd(OP_INSERT, '0, 32'd9, 1'b1, 8'd0, 9'd0);
    send_cmd(OP_READ, '0, '0, 1'b0, 8'd255, 9'd256);
    send_cmd(OP_READ, '0, '0, 1'b0, 8'd255, 9'd255);
    send_cmd(OP_READ, '0, '0, 1'b0, 8'd0, 9'd511);
    send_cmd(OP_READ, '0, '0, 1'b0, 8'd128, 9'd0);
    send_cmd(OP_CLEAR, '0, '0, 1'b0, 8'd0, 9'd0);
    send_cmd(OP_READ, '0, '0, 1'b0, 8'd0, 9'd256);
  endtask

  // mostly inserts, often of held keys, with reads, clears and noise
  task automatic test_random_traffic(input int n_items, input int idle);
    int          roll;
    int          pick;
    logic [1:0]  op;
    logic [63:0] key;
    logic [31:0] stamp;
    logic [7:0]  idx;
    logic [8:0]  lim;
    send_idle_pct = idle;
    repeat (n_items) begin
      roll = $urandom_range(99);
      if (roll < 57) op = OP_INSERT;
      else if (roll < 90) op = OP_READ;
      else if (roll < 97) op = OP_UNUSED;
      else op = OP_CLEAR;
      // key: sometimes zero, often one already held
      key = {$urandom, $urandom};
      pick = $urandom_range(9);
      if (pick == 0) key = '0;
      else if (pick < 6 && shadow_count > 0)
        key = shadow_key[$urandom_range(shadow_count - 1)];
      stamp = ($urandom_range(2) == 0) ? '0 : $urandom;
      // index mostly around the filled part of the table
      if ($urandom_range(4) == 0) idx = 8'($urandom_range(255));
      else idx = (shadow_count > 255) ? 8'd255 : 8'($urandom_range(shadow_count));
      pick = $urandom_range(9);
      if (pick < 7) lim = 9'd256;
      else if (pick < 9) lim = 9'($urandom_range(511));
      else lim = {1'b0, idx};
      send_cmd(op, key, stamp, 1'($urandom_range(1)), idx, lim);
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_opcode <= OP_INSERT;
    in_key_hash <= '0;
    in_stamp <= '0;
    in_unloaded_mark <= 1'b0;
    in_read_index <= '0;
    in_read_limit <= '0;
    send_idle_pct = 0;
    fail_count = 0;
    shadow_count = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_full_table();
    test_random_traffic(500, 0);
    test_random_traffic(500, 80);
    test_random_traffic(500, 0);
    test_random_traffic(500, 14);

    wait_for_replies();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
